// ----- hw/rtl/scsw_pkg.sv -----
// Shared types, constants and the position-to-chip mapping for the
// sensor channel staleness watchdog. No dependencies.
`timescale 1ns / 1ps

package scsw_pkg;

   localparam int CHIP_COUNT = 32;
   localparam int CHIP_W     = 5;
   localparam int MAX_SLOTS  = 2;

   // action codes
   localparam logic [1:0] ACT_UPDATE  = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // unreliable_event codes
   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_UNRELIABLE = 2'd1;
   localparam logic [1:0] EV_RELIABLE   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_SLOT_ENABLE = 2'd0;
   localparam logic [1:0] REG_LIMIT       = 2'd1;
   localparam logic [1:0] REG_TRIGGER     = 2'd2;

   localparam logic [1:0]  SLOT_ENABLE_RESET = 2'd3;
   localparam logic [31:0] LIMIT_RESET_MS    = 32'd20000;
   localparam logic [31:0] TRIGGER_RESET_MS  = 32'd30000;

   localparam logic [3:0] POS_DIE_MAP [2][8] = '{
      '{4'd13, 4'd15, 4'd9, 4'd11, 4'd5, 4'd7, 4'd1, 4'd3},
      '{4'd2, 4'd0, 4'd6, 4'd4, 4'd10, 4'd8, 4'd14, 4'd12}
   };

   typedef struct packed {
      logic [1:0]  action;
      logic        slot;
      logic [5:0]  position;
      logic [31:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic        report_slot;
      logic [31:0] overdue_mask;
      logic [31:0] report_time;
      logic        unreliable;
      logic [1:0]  unreliable_event;
      logic        last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UPDATE,
      ST_RESTART,
      ST_SLOT,
      ST_READ,
      ST_DRAIN,
      ST_APPLY,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic              load;
      logic              update;
      logic              restart;
      logic              scan_clear;
      logic              rd_en;
      logic              apply;
      logic              emit;
      logic              slot;
      logic [CHIP_W-1:0] chip;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0]           action;
      logic                 pipe_busy;
      logic                 out_free;
      logic [MAX_SLOTS-1:0] pend;
   } dp_status_type;

   // die = table entry + 16 * (3 - position[4:3]); chip folds die bit 1 into bit 0
   function automatic logic [CHIP_W-1:0] chip_of_position(input logic [5:0] pos);
      logic [3:0] die_low;
      logic [1:0] die_high;
      logic [5:0] die;
      die_low  = POS_DIE_MAP[pos[5]][pos[2:0]];
      die_high = 2'd3 - pos[4:3];
      die      = {die_high, die_low};
      return {die[5:2], die[1] ^ die[0]};
   endfunction

endpackage

// ----- hw/rtl/scsw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/scsw_csr.sv -----
// APB-style configuration registers: slot enable, limit and trigger ages.
// Depends on scsw_pkg.
`timescale 1ns / 1ps

module scsw_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [1:0]  slot_enable,
   output logic [31:0] limit_ms,
   output logic [31:0] trigger_ms
);
   import scsw_pkg::*;

   logic [1:0]  slot_enable_ff, slot_enable_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] trigger_ff, trigger_in;
   logic        wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      slot_enable_in = slot_enable_ff;
      limit_in       = limit_ff;
      trigger_in     = trigger_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SLOT_ENABLE: slot_enable_in = pwdata[1:0];
            REG_LIMIT:       limit_in       = pwdata;
            REG_TRIGGER:     trigger_in     = pwdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_enable_ff <= SLOT_ENABLE_RESET;
         limit_ff       <= LIMIT_RESET_MS;
         trigger_ff     <= TRIGGER_RESET_MS;
      end else begin
         slot_enable_ff <= slot_enable_in;
         limit_ff       <= limit_in;
         trigger_ff     <= trigger_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SLOT_ENABLE: prdata = {30'b0, slot_enable_ff};
         REG_LIMIT:       prdata = limit_ff;
         REG_TRIGGER:     prdata = trigger_ff;
         default:         prdata = 32'b0;
      endcase
   end

   assign pready      = 1'b1;
   assign slot_enable = slot_enable_ff;
   assign limit_ms    = limit_ff;
   assign trigger_ms  = trigger_ff;

endmodule

// ----- hw/rtl/scsw_ctrl.sv -----
// Sequencer: dispatches each transaction, walks slots and chips for a tick
// and hands reports to the datapath. Depends on scsw_pkg.
`timescale 1ns / 1ps

module scsw_ctrl #(
   parameter int SLOT_COUNT = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              slot_enable,
   input  scsw_pkg::dp_status_type status,
   output scsw_pkg::ctrl_cmd_type  cmd
);
   import scsw_pkg::*;

   localparam logic              SLOT_LAST = 1'(SLOT_COUNT - 1);
   localparam logic [CHIP_W-1:0] CHIP_LAST = CHIP_W'(CHIP_COUNT - 1);

   ctrl_state_type    state_ff, state_in;
   logic              slot_ff, slot_in;
   logic [CHIP_W-1:0] chip_ff, chip_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= 1'b0;
         chip_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         chip_ff  <= chip_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      chip_in   = chip_ff;
      cmd       = '0;
      cmd.slot  = slot_ff;
      cmd.chip  = chip_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            slot_in = 1'b0;
            case (status.action)
               ACT_UPDATE:  state_in = ST_UPDATE;
               ACT_TICK:    state_in = ST_SLOT;
               ACT_RESTART: state_in = ST_RESTART;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_SLOT: begin
            if (slot_enable[slot_ff]) begin
               cmd.scan_clear = 1'b1;
               chip_in        = '0;
               state_in       = ST_READ;
            end else if (slot_ff == SLOT_LAST) begin
               slot_in  = 1'b0;
               state_in = ST_EMIT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            chip_in   = chip_ff + 1'b1;
            if (chip_ff == CHIP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (slot_ff == SLOT_LAST) begin
               slot_in  = 1'b0;
               state_in = ST_EMIT;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_SLOT;
            end
         end
         ST_EMIT: begin
            // one pending report per slot, in slot order
            if (!status.pend[slot_ff] || status.out_free) begin
               cmd.emit = status.pend[slot_ff];
               if (slot_ff == SLOT_LAST) begin
                  slot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/scsw_dp.sv -----
// Datapath: last-seen RAM with valid bits, age pipeline, overdue marks,
// warning state and the report output register.
// Depends on scsw_pkg and scsw_ram.
`timescale 1ns / 1ps

module scsw_dp #(
   parameter int SLOT_COUNT = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scsw_pkg::ctrl_cmd_type    cmd,
   output scsw_pkg::dp_status_type   status,
   input  scsw_pkg::req_payload_type req_data,
   input  logic [31:0]               limit_ms,
   input  logic [31:0]               trigger_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output scsw_pkg::rsp_payload_type rsp_data
);
   import scsw_pkg::*;

   localparam int DEPTH  = SLOT_COUNT * CHIP_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [MAX_SLOTS-1:0] PEND_ALL = MAX_SLOTS'((1 << SLOT_COUNT) - 1);

   req_payload_type in_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [31:0] base_ff, base_in;
   logic [SLOT_COUNT-1:0][CHIP_COUNT-1:0] marks_ff, marks_in;
   logic [MAX_SLOTS-1:0] warn_ff, warn_in;
   logic flag_ff, flag_in;
   logic [MAX_SLOTS-1:0] pend_ff, pend_in;
   logic p1_valid_ff, p2_valid_ff;
   logic p1_vbit_ff;
   logic [CHIP_W-1:0] p1_chip_ff, p2_chip_ff;
   logic [31:0] age_ff;
   logic hit_ff, hit_in;
   logic [CHIP_COUNT-1:0] cand_ff, cand_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [CHIP_W-1:0] upd_chip;
   logic upd_slot_ok;
   logic [ADDR_W-1:0] upd_addr, rd_addr;
   logic [31:0] rd_data, seen_time;
   logic [CHIP_COUNT-1:0] emit_mask;
   logic [MAX_SLOTS-1:0] warn_next;
   logic flag_next;
   logic [1:0] ev;
   logic out_free;

   assign upd_chip    = chip_of_position(in_ff.position);
   assign upd_slot_ok = {1'b0, in_ff.slot} < 2'(SLOT_COUNT);
   assign upd_addr    = ADDR_W'({in_ff.slot, upd_chip});
   assign rd_addr     = ADDR_W'({cmd.slot, cmd.chip});

   scsw_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_last_seen (
      .clock  (clock),
      .wr_en  (cmd.update && upd_slot_ok),
      .wr_addr(upd_addr),
      .wr_data(in_ff.time_ms),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // entries not written since the last restart (or reset) hold the base time
   assign seen_time = p1_vbit_ff ? rd_data : base_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      emit_mask = marks_ff[cmd.slot];
      warn_next = warn_ff;
      flag_next = flag_ff;
      ev        = EV_NONE;
      if (emit_mask == '0) begin
         warn_next[cmd.slot] = 1'b0;
         if (flag_ff && warn_next == '0) begin
            flag_next = 1'b0;
            ev        = EV_RELIABLE;
         end
      end else begin
         warn_next[cmd.slot] = 1'b1;
         if (!flag_ff) begin
            flag_next = 1'b1;
            ev        = EV_UNRELIABLE;
         end
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      base_in      = base_ff;
      marks_in     = marks_ff;
      warn_in      = warn_ff;
      flag_in      = flag_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         pend_in = '0;
      end
      if (cmd.update && upd_slot_ok) begin
         valid_in[upd_addr] = 1'b1;
         if (marks_ff[in_ff.slot][upd_chip]) begin
            marks_in[in_ff.slot][upd_chip] = 1'b0;
            pend_in[in_ff.slot]            = 1'b1;
         end
      end
      if (cmd.restart) begin
         valid_in = '0;
         base_in  = in_ff.time_ms;
         marks_in = '0;
         pend_in  = PEND_ALL;
      end

      if (cmd.scan_clear) begin
         hit_in  = 1'b0;
         cand_in = '0;
      end else if (p2_valid_ff) begin
         if (age_ff >= trigger_ms) begin
            hit_in = 1'b1;
         end
         if (age_ff > limit_ms) begin
            cand_in[p2_chip_ff] = 1'b1;
         end
      end

      if (cmd.apply && hit_ff) begin
         marks_in[cmd.slot] = marks_ff[cmd.slot] | cand_ff;
         pend_in[cmd.slot]  = |(cand_ff & ~marks_ff[cmd.slot]);
      end

      if (cmd.emit) begin
         warn_in                      = warn_next;
         flag_in                      = flag_next;
         pend_in[cmd.slot]            = 1'b0;
         rsp_valid_in                 = 1'b1;
         rsp_data_in.report_slot      = cmd.slot;
         rsp_data_in.overdue_mask     = emit_mask;
         rsp_data_in.report_time      = in_ff.time_ms;
         rsp_data_in.unreliable       = flag_next;
         rsp_data_in.unreliable_event = ev;
         // final report when no later slot still waits
         rsp_data_in.last             = (cmd.slot == 1'b1) || !pend_ff[1];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         base_ff      <= '0;
         marks_ff     <= '0;
         warn_ff      <= '0;
         flag_ff      <= 1'b0;
         pend_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         base_ff      <= base_in;
         marks_ff     <= marks_in;
         warn_ff      <= warn_in;
         flag_ff      <= flag_in;
         pend_ff      <= pend_in;
         p1_valid_ff  <= cmd.rd_en;
         p2_valid_ff  <= p1_valid_ff;
         hit_ff       <= hit_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      p1_vbit_ff  <= valid_ff[rd_addr];
      p1_chip_ff  <= cmd.chip;
      p2_chip_ff  <= p1_chip_ff;
      age_ff      <= in_ff.time_ms - seen_time;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.action    = in_ff.action;
   assign status.pipe_busy = p1_valid_ff || p2_valid_ff;
   assign status.out_free  = out_free;
   assign status.pend      = pend_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/sensor_channel_staleness_watchdog.sv -----
// Staleness watchdog for temperature-sensor channels, 32 chips per slot.
// req channel: one transaction per event (sensor update, tick, restart);
//    req_stall is low only while the block is idle.
// rsp channel: overdue reports, at most one per slot per transaction,
//    flagged last on the final one; an output register holds each report.
// APB port: slot_enable at 0x0, limit_ms at 0x4, trigger_ms at 0x8.
// Sequence per transaction, from acceptance until the block is idle:
//    update and restart each do one datapath step, then the report pass;
//    an unknown action returns straight to idle; a tick sets up each
//    enabled slot, reads its 32 chips from the last-seen RAM, drains the
//    age pipeline and applies the marks, skips disabled slots, then runs
//    the report pass. The single read port of the last-seen RAM paces the
//    tick. A receiver holding rsp_stall on a report lengthens a transaction.
// Reset: every channel reads as seen at time 0, all marks and the
//    unreliable flag clear, registers return to their defaults. There is
//    no clearing pass; valid bits cover the RAM.
// While rsp_stall is high the waiting report holds and the sequencer
//    waits before issuing the next one; a new transaction is taken once
//    the sequencer has handed off its last report.
// Depends on scsw_pkg, scsw_csr, scsw_ctrl, scsw_dp, scsw_ram.
`timescale 1ns / 1ps

module sensor_channel_staleness_watchdog #(
   parameter int SLOT_COUNT = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  scsw_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output scsw_pkg::rsp_payload_type rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import scsw_pkg::*;

   logic [1:0]    slot_enable;
   logic [31:0]   limit_ms;
   logic [31:0]   trigger_ms;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   scsw_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .slot_enable(slot_enable),
      .limit_ms   (limit_ms),
      .trigger_ms (trigger_ms)
   );

   scsw_ctrl #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .slot_enable(slot_enable),
      .status     (status),
      .cmd        (cmd)
   );

   scsw_dp #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .limit_ms  (limit_ms),
      .trigger_ms(trigger_ms),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/scsw_checker.sv -----
// Port-level checks for the staleness watchdog, bound to the top level.
// Depends on scsw_pkg and sensor_channel_staleness_watchdog.
`timescale 1ns / 1ps

module scsw_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input scsw_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input scsw_pkg::rsp_payload_type rsp_data
);
   import scsw_pkg::*;

   // no report survives reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report visible after reset");

   // a stalled report holds
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled report changed");

   // one transaction at a time: stall right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // an overdue mask means the block is unreliable
   a_mask_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overdue_mask != '0 |->
         rsp_data.unreliable && rsp_data.unreliable_event != EV_RELIABLE)
      else $error("overdue report without unreliable flag");

endmodule

bind sensor_channel_staleness_watchdog scsw_checker u_scsw_checker (.*);
